>>> hdl/extended_interval_alu_core_defines.svh
`ifndef EXTENDED_INTERVAL_ALU_CORE_DEFINES_SVH
`define EXTENDED_INTERVAL_ALU_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EIA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EIA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/eia_pkg.sv
`default_nettype none

package eia_pkg;

   typedef enum logic [2:0] {
      ACT_ADD       = 3'd0,
      ACT_SUBTRACT  = 3'd1,
      ACT_MULTIPLY  = 3'd2,
      ACT_DIVIDE    = 3'd3,
      ACT_INTERSECT = 3'd4,
      ACT_TIGHTEN   = 3'd5
   } action_type;

   localparam int NUM_LANES = 4;

endpackage

`default_nettype wire

>>> hdl/eia_req_if.sv
`default_nettype none

interface eia_req_if import eia_pkg::*; #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   action_type                    action;
   logic signed [VALUE_WIDTH-1:0] a_low;
   logic signed [VALUE_WIDTH-1:0] a_high;
   logic                          a_low_unbounded;
   logic                          a_high_unbounded;
   logic signed [VALUE_WIDTH-1:0] b_low;
   logic signed [VALUE_WIDTH-1:0] b_high;
   logic                          b_low_unbounded;
   logic                          b_high_unbounded;

   modport source (output valid, action, a_low, a_high, a_low_unbounded, a_high_unbounded,
                   b_low, b_high, b_low_unbounded, b_high_unbounded, input ready);
   modport sink (input valid, action, a_low, a_high, a_low_unbounded, a_high_unbounded,
                 b_low, b_high, b_low_unbounded, b_high_unbounded, output ready);
endinterface

`default_nettype wire

>>> hdl/eia_rsp_if.sv
`default_nettype none

interface eia_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] res_low;
   logic signed [VALUE_WIDTH-1:0] res_high;
   logic                          res_low_unbounded;
   logic                          res_high_unbounded;
   logic                          overlap;
   logic                          changed;

   modport source (output valid, res_low, res_high, res_low_unbounded, res_high_unbounded,
                   overlap, changed, input ready);
   modport sink (input valid, res_low, res_high, res_low_unbounded, res_high_unbounded,
                 overlap, changed, output ready);
endinterface

`default_nettype wire

>>> hdl/eia_div_cell.sv
`default_nettype none

module eia_div_cell import eia_pkg::*; #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRAC_BITS     = 16,
   parameter int PAYLOAD_WIDTH = 1,
   localparam int QuoWidth     = VALUE_WIDTH + FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     prev_valid,
   input  logic [PAYLOAD_WIDTH-1:0] prev_payload,
   input  logic [VALUE_WIDTH-1:0]   prev_rem [NUM_LANES],
   input  logic [QuoWidth-1:0]      prev_num [NUM_LANES],
   input  logic [QuoWidth-1:0]      prev_quo [NUM_LANES],
   input  logic [VALUE_WIDTH-1:0]   prev_den [NUM_LANES],
   output logic                     valid_ff,
   output logic [PAYLOAD_WIDTH-1:0] payload_ff,
   output logic [VALUE_WIDTH-1:0]   rem_ff [NUM_LANES],
   output logic [QuoWidth-1:0]      num_ff [NUM_LANES],
   output logic [QuoWidth-1:0]      quo_ff [NUM_LANES],
   output logic [VALUE_WIDTH-1:0]   den_ff [NUM_LANES]
);

   logic [VALUE_WIDTH-1:0] rem_in [NUM_LANES];
   logic [QuoWidth-1:0]    num_in [NUM_LANES];
   logic [QuoWidth-1:0]    quo_in [NUM_LANES];

   // One restoring step per lane: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         logic [VALUE_WIDTH:0] trial;
         logic [VALUE_WIDTH:0] diff;
         logic                 fits;
         trial = {prev_rem[i], prev_num[i][QuoWidth-1]};
         diff = trial - {1'b0, prev_den[i]};
         fits = (trial >= {1'b0, prev_den[i]});
         rem_in[i] = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         num_in[i] = prev_num[i] << 1;
         quo_in[i] = {prev_quo[i][QuoWidth-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
      if (advance) begin
         payload_ff <= prev_payload;
         rem_ff     <= rem_in;
         num_ff     <= num_in;
         quo_ff     <= quo_in;
         den_ff     <= prev_den;
      end
   end

endmodule

`default_nettype wire

>>> hdl/extended_interval_alu_core.sv
// Channel  | Direction | Contents
// req_ch   | in        | action, intervals A and B with unbounded-end flags
// rsp_ch   | out       | result interval, flags, overlap, changed
//
// One item is accepted every cycle while the pipeline is not held.
// The row of division cells yields one quotient bit per cell.
// Reset is synchronous and clears only the valid bits of the pipeline.
// When the output register holds an item that is not taken, the whole pipeline holds.
`default_nettype none
`include "extended_interval_alu_core_defines.svh"

module extended_interval_alu_core import eia_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic      clock,
   input logic      reset,
   eia_req_if.sink  req_ch,
   eia_rsp_if.source rsp_ch
);

   localparam int W  = VALUE_WIDTH;
   localparam int QW = VALUE_WIDTH + FRAC_BITS;
   localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      action_type          action;
      logic signed [W-1:0] a_low;
      logic signed [W-1:0] a_high;
      logic                a_low_inf;
      logic                a_high_inf;
      logic signed [W-1:0] b_low;
      logic signed [W-1:0] b_high;
      logic                b_low_inf;
      logic                b_high_inf;
   } item_type;

   typedef struct packed {
      item_type                      item;
      logic [NUM_LANES-1:0][W-1:0]   mul;
   } chain_type;

   localparam int PW = $bits(chain_type);

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} + {y[W-1], y};
      if (s[W] != s[W-1]) return s[W] ? MinV : MaxV;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} - {y[W-1], y};
      if (s[W] != s[W-1]) return s[W] ? MinV : MaxV;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] lane_x(input item_type it, input int k);
      return k[1] ? it.a_high : it.a_low;
   endfunction

   function automatic logic signed [W-1:0] lane_y(input item_type it, input int k);
      return k[0] ? it.b_high : it.b_low;
   endfunction

   function automatic logic lane_en(input item_type it, input int k);
      return !(k[1] ? it.a_high_inf : it.a_low_inf) && !(k[0] ? it.b_high_inf : it.b_low_inf);
   endfunction

   logic adv;
   logic out_valid_ff;

   assign adv = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Input register.
   logic     s0_valid_ff;
   item_type s0_item_ff;
   item_type s0_item_in;

   always_comb begin
      s0_item_in.action     = req_ch.action;
      s0_item_in.a_low      = req_ch.a_low;
      s0_item_in.a_high     = req_ch.a_high;
      s0_item_in.a_low_inf  = req_ch.a_low_unbounded;
      s0_item_in.a_high_inf = req_ch.a_high_unbounded;
      s0_item_in.b_low      = req_ch.b_low;
      s0_item_in.b_high     = req_ch.b_high;
      s0_item_in.b_low_inf  = req_ch.b_low_unbounded;
      s0_item_in.b_high_inf = req_ch.b_high_unbounded;
   end

   // Product register: magnitudes of the four endpoint products.
   logic             s1_valid_ff;
   item_type         s1_item_ff;
   logic [2*W-1:0]   s1_prod_ff [NUM_LANES];
   logic [2*W-1:0]   s1_prod_in [NUM_LANES];

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         s1_prod_in[k] = (2*W)'(mag(lane_x(s0_item_ff, k))) *
                         (2*W)'(mag(lane_y(s0_item_ff, k)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_ch.valid;
         s1_valid_ff <= s0_valid_ff;
      end
      if (adv) begin
         s0_item_ff <= s0_item_in;
         s1_item_ff <= s0_item_ff;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Row of division cells.
   logic             ch_valid [QW+1];
   logic [PW-1:0]    ch_pay   [QW+1];
   logic [W-1:0]     ch_rem   [QW+1][NUM_LANES];
   logic [QW-1:0]    ch_num   [QW+1][NUM_LANES];
   logic [QW-1:0]    ch_quo   [QW+1][NUM_LANES];
   logic [W-1:0]     ch_den   [QW+1][NUM_LANES];
   chain_type        head;

   always_comb begin
      head.item = s1_item_ff;
      for (int k = 0; k < NUM_LANES; k++) begin
         logic           neg;
         logic [2*W-1:0] shifted;
         logic [2*W-1:0] lim;
         logic [2*W-1:0] satv;
         neg = (lane_x(s1_item_ff, k) < 0) != (lane_y(s1_item_ff, k) < 0);
         shifted = s1_prod_ff[k] >> FRAC_BITS;
         lim = ((2*W)'(1) << (W-1)) - (neg ? (2*W)'(0) : (2*W)'(1));
         satv = (shifted > lim) ? lim : shifted;
         head.mul[k] = neg ? W'(-satv[W-1:0]) : satv[W-1:0];
         ch_rem[0][k] = '0;
         ch_num[0][k] = QW'(mag(lane_x(s1_item_ff, k))) << FRAC_BITS;
         ch_quo[0][k] = '0;
         ch_den[0][k] = mag(lane_y(s1_item_ff, k));
      end
      ch_valid[0] = s1_valid_ff;
      ch_pay[0] = head;
   end

   for (genvar c = 0; c < QW; c++) begin : g_cell
      eia_div_cell #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .FRAC_BITS     (FRAC_BITS),
         .PAYLOAD_WIDTH (PW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (adv),
         .prev_valid   (ch_valid[c]),
         .prev_payload (ch_pay[c]),
         .prev_rem     (ch_rem[c]),
         .prev_num     (ch_num[c]),
         .prev_quo     (ch_quo[c]),
         .prev_den     (ch_den[c]),
         .valid_ff     (ch_valid[c+1]),
         .payload_ff   (ch_pay[c+1]),
         .rem_ff       (ch_rem[c+1]),
         .num_ff       (ch_num[c+1]),
         .quo_ff       (ch_quo[c+1]),
         .den_ff       (ch_den[c+1])
      );
   end

   // Finish stage: ranges of products and quotients.
   chain_type           tail;
   item_type            ti;
   logic signed [W-1:0] mul_lo_in, mul_hi_in, div_lo_in, div_hi_in;
   logic                mul_li_in, mul_hi_inf_in, div_li_in, div_hi_inf_in;

   always_comb begin
      logic                mset, dset;
      logic signed [W-1:0] qv;
      logic                nposv, nnegv, deps, dneps;
      tail = chain_type'(ch_pay[QW]);
      ti = tail.item;
      mset = 1'b0;
      dset = 1'b0;
      mul_lo_in = '0;
      mul_hi_in = '0;
      div_lo_in = '0;
      div_hi_in = '0;
      for (int k = 0; k < NUM_LANES; k++) begin
         logic           neg;
         logic [QW-1:0]  lim;
         logic [QW-1:0]  satq;
         neg = (lane_x(ti, k) < 0) != (lane_y(ti, k) < 0);
         lim = (QW'(1) << (W-1)) - (neg ? QW'(0) : QW'(1));
         satq = (ch_quo[QW][k] > lim) ? lim : ch_quo[QW][k];
         if (lane_y(ti, k) == '0) begin
            qv = (lane_x(ti, k) < 0) ? MinV : ((lane_x(ti, k) == '0) ? '0 : MaxV);
         end else begin
            qv = neg ? W'(-satq[W-1:0]) : satq[W-1:0];
         end
         if (lane_en(ti, k)) begin
            if (!mset || ($signed(tail.mul[k]) < mul_lo_in)) mul_lo_in = tail.mul[k];
            if (!mset || ($signed(tail.mul[k]) > mul_hi_in)) mul_hi_in = tail.mul[k];
            if (!dset || (qv < div_lo_in)) div_lo_in = qv;
            if (!dset || (qv > div_hi_in)) div_hi_in = qv;
            mset = 1'b1;
            dset = 1'b1;
         end
      end
      mul_li_in = (ti.a_low_inf && (ti.b_high_inf || ti.b_high > 0)) ||
                  (ti.b_low_inf && (ti.a_high_inf || ti.a_high > 0)) ||
                  (ti.a_high_inf && (ti.b_low_inf || ti.b_low < 0)) ||
                  (ti.b_high_inf && (ti.a_low_inf || ti.a_low < 0));
      mul_hi_inf_in = (ti.a_low_inf && (ti.b_low_inf || ti.b_low < 0)) ||
                      (ti.b_low_inf && (ti.a_low_inf || ti.a_low < 0)) ||
                      (ti.a_high_inf && (ti.b_high_inf || ti.b_high > 0)) ||
                      (ti.b_high_inf && (ti.a_high_inf || ti.a_high > 0));
      nposv = ti.a_high_inf || ti.a_high > 0;
      nnegv = ti.a_low_inf || ti.a_low < 0;
      deps  = (ti.b_low_inf || ti.b_low < 0) && (ti.b_high_inf || ti.b_high > 0);
      dneps = (ti.b_low_inf || ti.b_low < 0) && (ti.b_high_inf || ti.b_high >= 0);
      div_li_in = (ti.a_low_inf && (ti.b_high_inf || ti.b_high > 0)) ||
                  (ti.a_high_inf && (ti.b_low_inf || ti.b_low < 0)) ||
                  (nnegv && deps) || (nposv && dneps);
      div_hi_inf_in = (ti.a_low_inf && (ti.b_low_inf || ti.b_low < 0)) ||
                      (ti.a_high_inf && (ti.b_high_inf || ti.b_high > 0)) ||
                      (nnegv && dneps) || (nposv && deps);
   end

   logic                fin_valid_ff;
   item_type            fin_item_ff;
   logic signed [W-1:0] mul_lo_ff, mul_hi_ff, div_lo_ff, div_hi_ff;
   logic                mul_li_ff, mul_hi_inf_ff, div_li_ff, div_hi_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= ch_valid[QW];
      end
      if (adv) begin
         fin_item_ff   <= ti;
         mul_lo_ff     <= mul_lo_in;
         mul_hi_ff     <= mul_hi_in;
         mul_li_ff     <= mul_li_in;
         mul_hi_inf_ff <= mul_hi_inf_in;
         div_lo_ff     <= div_lo_in;
         div_hi_ff     <= div_hi_in;
         div_li_ff     <= div_li_in;
         div_hi_inf_ff <= div_hi_inf_in;
      end
   end

   // Result selection.
   item_type            fi;
   logic signed [W-1:0] res_lo_in, res_hi_in;
   logic                res_li_in, res_hi_inf_in, overlap_in, changed_in;

   always_comb begin
      logic                a_empty, b_empty, below, known;
      logic signed [W-1:0] i_lo, i_hi;
      logic                i_li, i_hi_inf;
      fi = fin_item_ff;
      a_empty = !fi.a_low_inf && !fi.a_high_inf && (fi.a_low > fi.a_high);
      b_empty = !fi.b_low_inf && !fi.b_high_inf && (fi.b_low > fi.b_high);
      overlap_in = !a_empty && !b_empty &&
                   (fi.a_low_inf || fi.b_high_inf || fi.a_low <= fi.b_high) &&
                   (fi.b_low_inf || fi.a_high_inf || fi.b_low <= fi.a_high);

      i_li = fi.a_low_inf && fi.b_low_inf;
      if (i_li) i_lo = '0;
      else if (fi.a_low_inf) i_lo = fi.b_low;
      else if (fi.b_low_inf) i_lo = fi.a_low;
      else i_lo = (fi.a_low > fi.b_low) ? fi.a_low : fi.b_low;
      i_hi_inf = fi.a_high_inf && fi.b_high_inf;
      if (i_hi_inf) i_hi = '0;
      else if (fi.a_high_inf) i_hi = fi.b_high;
      else if (fi.b_high_inf) i_hi = fi.a_high;
      else i_hi = (fi.a_high < fi.b_high) ? fi.a_high : fi.b_high;

      below = !fi.a_high_inf && !fi.b_low_inf && (fi.a_high < fi.b_low);
      known = 1'b1;
      res_lo_in = fi.a_low;
      res_hi_in = fi.a_high;
      res_li_in = fi.a_low_inf;
      res_hi_inf_in = fi.a_high_inf;

      case (fi.action)
         ACT_ADD: begin
            res_li_in = fi.a_low_inf || fi.b_low_inf;
            res_hi_inf_in = fi.a_high_inf || fi.b_high_inf;
            res_lo_in = sat_add(fi.a_low, fi.b_low);
            res_hi_in = sat_add(fi.a_high, fi.b_high);
         end
         ACT_SUBTRACT: begin
            res_li_in = fi.a_low_inf || fi.b_high_inf;
            res_hi_inf_in = fi.a_high_inf || fi.b_low_inf;
            res_lo_in = sat_sub(fi.a_low, fi.b_high);
            res_hi_in = sat_sub(fi.a_high, fi.b_low);
         end
         ACT_MULTIPLY: begin
            res_lo_in = mul_lo_ff;
            res_hi_in = mul_hi_ff;
            res_li_in = mul_li_ff;
            res_hi_inf_in = mul_hi_inf_ff;
         end
         ACT_DIVIDE: begin
            res_lo_in = div_lo_ff;
            res_hi_in = div_hi_ff;
            res_li_in = div_li_ff;
            res_hi_inf_in = div_hi_inf_ff;
         end
         ACT_INTERSECT: begin
            res_lo_in = i_lo;
            res_hi_in = i_hi;
            res_li_in = i_li;
            res_hi_inf_in = i_hi_inf;
         end
         ACT_TIGHTEN: begin
            if (overlap_in) begin
               res_lo_in = i_lo;
               res_hi_in = i_hi;
               res_li_in = i_li;
               res_hi_inf_in = i_hi_inf;
            end else begin
               res_lo_in = below ? fi.a_high : fi.a_low;
               res_hi_in = res_lo_in;
               res_li_in = 1'b0;
               res_hi_inf_in = 1'b0;
            end
         end
         default: known = 1'b0;
      endcase

      if (known && fi.action != ACT_TIGHTEN) begin
         if (res_li_in) res_lo_in = '0;
         if (res_hi_inf_in) res_hi_in = '0;
      end
      if (!known || a_empty) begin
         res_lo_in = fi.a_low;
         res_hi_in = fi.a_high;
         res_li_in = fi.a_low_inf;
         res_hi_inf_in = fi.a_high_inf;
      end else if (b_empty) begin
         res_lo_in = fi.b_low;
         res_hi_in = fi.b_high;
         res_li_in = fi.b_low_inf;
         res_hi_inf_in = fi.b_high_inf;
      end

      changed_in = known &&
                   ((res_li_in != fi.a_low_inf) || (res_hi_inf_in != fi.a_high_inf) ||
                    (!fi.a_low_inf && res_lo_in != fi.a_low) ||
                    (!fi.a_high_inf && res_hi_in != fi.a_high));
   end

   logic signed [W-1:0] out_lo_ff, out_hi_ff;
   logic                out_li_ff, out_hi_inf_ff, out_overlap_ff, out_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fin_valid_ff;
      end
      if (adv) begin
         out_lo_ff      <= res_lo_in;
         out_hi_ff      <= res_hi_in;
         out_li_ff      <= res_li_in;
         out_hi_inf_ff  <= res_hi_inf_in;
         out_overlap_ff <= overlap_in;
         out_changed_ff <= changed_in;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.res_low            = out_lo_ff;
   assign rsp_ch.res_high           = out_hi_ff;
   assign rsp_ch.res_low_unbounded  = out_li_ff;
   assign rsp_ch.res_high_unbounded = out_hi_inf_ff;
   assign rsp_ch.overlap            = out_overlap_ff;
   assign rsp_ch.changed            = out_changed_ff;

   `EIA_ASSERT_NEXT(a_stall_holds_s1, s1_valid_ff && !adv, s1_valid_ff, "Item lost in a stall.")
   `EIA_ASSERT_NEXT(a_fin_reaches_out, fin_valid_ff && adv, out_valid_ff, "Item dropped at output.")
   `EIA_ASSERT_NOW(a_ready_when_empty, !out_valid_ff, req_ch.ready, "Ready low with empty output.")

endmodule

`default_nettype wire
